### src/masked_rgb_pixel_format_convert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel format converter
// Shorthand for clocked assertions, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef MASKED_RGB_PIXEL_FORMAT_CONVERT_MACROS_SVH
`define MASKED_RGB_PIXEL_FORMAT_CONVERT_MACROS_SVH

// assertion that is switched off while reset is high
`define MRPFC_ASSERT_RST(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pixel format converter check failed");

// assertion that also holds across reset
`define MRPFC_ASSERT(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("pixel format converter check failed");

`endif

### src/mrpfc_pkg.sv
// ----------------------------------------------------------------------------
// mrpfc_pkg
// Types and constants shared by the masked RGB pixel format converter.
// ----------------------------------------------------------------------------
package mrpfc_pkg;

   // sizes
   localparam int MAX_ROW_PIXELS_DEF = 4096;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int ACC_W              = 40;
   localparam int SB_W               = 6;
   localparam int ROW_PIX_REG_W      = 13;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_BITS   = 3'd0,
      CSR_RED_MASK      = 3'd1,
      CSR_GREEN_MASK    = 3'd2,
      CSR_BLUE_MASK     = 3'd3,
      CSR_ALPHA_PRESENT = 3'd4,
      CSR_TARGET_FORMAT = 3'd5,
      CSR_ROW_PIXELS    = 3'd6
   } csr_index_type;

   // target layouts
   typedef enum logic [1:0] {
      FMT_RGB555   = 2'd0,
      FMT_RGB888   = 2'd1,
      FMT_XRGB8888 = 2'd2
   } target_format_type;

   // register reset values
   localparam logic [SB_W-1:0]          SOURCE_BITS_RST = 6'd16;
   localparam logic [31:0]              RED_MASK_RST    = 32'h0000_7c00;
   localparam logic [31:0]              GREEN_MASK_RST  = 32'h0000_03e0;
   localparam logic [31:0]              BLUE_MASK_RST   = 32'h0000_001f;
   localparam logic [1:0]               TARGET_FMT_RST  = FMT_RGB555;
   localparam logic [ROW_PIX_REG_W-1:0] ROW_PIXELS_RST  = 13'd1;

   // source pixel width bounds
   localparam logic [SB_W-1:0] SRC_BITS_MIN = 6'd9;
   localparam logic [SB_W-1:0] SRC_BITS_MAX = 6'd32;

   // target field masks
   localparam logic [31:0] MASK555_R = 32'h0000_7c00;
   localparam logic [31:0] MASK555_G = 32'h0000_03e0;
   localparam logic [31:0] MASK555_B = 32'h0000_001f;
   localparam logic [31:0] MASK888_R = 32'h00ff_0000;
   localparam logic [31:0] MASK888_G = 32'h0000_ff00;
   localparam logic [31:0] MASK888_B = 32'h0000_00ff;

   // target pixel widths and field widths
   localparam logic [SB_W-1:0] TBITS_555   = 6'd16;
   localparam logic [SB_W-1:0] TBITS_888   = 6'd24;
   localparam logic [SB_W-1:0] TBITS_8888  = 6'd32;
   localparam logic [3:0]      FIELD_W_555 = 4'd5;
   localparam logic [3:0]      FIELD_W_888 = 4'd8;

endpackage

### src/masked_rgb_pixel_format_convert.sv
// ----------------------------------------------------------------------------
// masked_rgb_pixel_format_convert
// Converts a packed bitfield RGB scanline byte stream to 555 or 888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one scanline byte per word, row padding included. Source
//   pixels are packed LSB first; each row is padded to a 4-byte boundary.
//   rsp_* carries one converted pixel per word, with rsp_row_last set on the
//   final pixel of a row. Padding bytes are taken but produce no word.
//   csr_* writes the format registers; write only while the block is idle.
// Timing:
//   Unless a result stalls, a byte is taken every clock: one byte per cycle,
//   set by the single result register behind the unpack and convert logic.
//   The pixel a byte completes shows on rsp_* the cycle after its acceptance.
// Reset:
//   Synchronous reset restores the default 16-bit 555 source format, a row of
//   one pixel, and clears the accumulator, the counters and the result valid.
// Stall:
//   While a result waits and rsp_ready is low, req_ready drops; it stays high
//   when the pending result is taken in the same cycle.
// ----------------------------------------------------------------------------
module masked_rgb_pixel_format_convert
   import mrpfc_pkg::*;
#(
   parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_src_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_pixel_out,
   output logic                   rsp_row_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIX_W  = $clog2(MAX_ROW_PIXELS + 1);
   localparam int BYTE_W = PIX_W + 2;
   localparam int PROD_W = PIX_W + SB_W;

   // narrow one field: shift out low bits so the span fits the target width
   function automatic logic [7:0] pick_field(logic [31:0] code, logic [31:0] mask,
                                             logic [3:0] fbits);
      logic [SB_W-1:0] lo;
      logic [SB_W-1:0] hi1;
      logic [SB_W-1:0] lo_top;
      logic [SB_W-1:0] sh;
      lo  = '0;
      hi1 = '0;
      for (int i = 31; i >= 0; i--) begin
         if (mask[i]) lo = SB_W'(i);
      end
      for (int i = 0; i < 32; i++) begin
         if (mask[i]) hi1 = SB_W'(i + 1);
      end
      lo_top = lo + SB_W'(fbits);
      sh = (hi1 > lo_top) ? (hi1 - SB_W'(fbits)) : lo;
      return 8'((code & mask) >> sh);
   endfunction

   // configuration registers
   logic [SB_W-1:0]          source_bits_ff;
   logic [31:0]              red_mask_ff;
   logic [31:0]              green_mask_ff;
   logic [31:0]              blue_mask_ff;
   logic                     alpha_present_ff;
   logic [1:0]               target_format_ff;
   logic [ROW_PIX_REG_W-1:0] row_pixels_ff;

   // row state
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [SB_W-1:0]   held_ff, held_in;
   logic [PIX_W-1:0]  pixel_ff, pixel_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_pixel_ff;
   logic        rsp_last_ff;

   // datapath
   logic [SB_W-1:0]   sb;
   logic [PIX_W-1:0]  rp;
   target_format_type fmt;
   logic [PROD_W-1:0] row_bits;
   logic [BYTE_W-1:0] row_bytes;
   logic [ACC_W-1:0]  acc_merge;
   logic [SB_W-1:0]   held_sum;
   logic [31:0]       code;
   logic              pix_open;
   logic              emit;
   logic [PIX_W:0]    pixel_inc;
   logic [BYTE_W:0]   byte_inc;
   logic              row_done;
   logic [3:0]        fbits;
   logic [SB_W-1:0]   tbits;
   logic [31:0]       tmask_r, tmask_g, tmask_b;
   logic [7:0]        fld_r, fld_g, fld_b;
   logic              passthrough;
   logic [31:0]       pixel_value;
   logic              req_fire;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_bits_ff   <= SOURCE_BITS_RST;
         red_mask_ff      <= RED_MASK_RST;
         green_mask_ff    <= GREEN_MASK_RST;
         blue_mask_ff     <= BLUE_MASK_RST;
         alpha_present_ff <= 1'b0;
         target_format_ff <= TARGET_FMT_RST;
         row_pixels_ff    <= ROW_PIXELS_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_BITS:   source_bits_ff   <= csr_wdata[SB_W-1:0];
            CSR_RED_MASK:      red_mask_ff      <= csr_wdata;
            CSR_GREEN_MASK:    green_mask_ff    <= csr_wdata;
            CSR_BLUE_MASK:     blue_mask_ff     <= csr_wdata;
            CSR_ALPHA_PRESENT: alpha_present_ff <= csr_wdata[0];
            CSR_TARGET_FORMAT: target_format_ff <= csr_wdata[1:0];
            CSR_ROW_PIXELS:    row_pixels_ff    <= csr_wdata[ROW_PIX_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the format registers to their legal ranges
   always_comb begin
      if (source_bits_ff < SRC_BITS_MIN) begin
         sb = SRC_BITS_MIN;
      end else if (source_bits_ff > SRC_BITS_MAX) begin
         sb = SRC_BITS_MAX;
      end else begin
         sb = source_bits_ff;
      end

      if (row_pixels_ff == '0) begin
         rp = PIX_W'(1);
      end else if (32'(row_pixels_ff) > 32'(MAX_ROW_PIXELS)) begin
         rp = PIX_W'(MAX_ROW_PIXELS);
      end else begin
         rp = PIX_W'(row_pixels_ff);
      end

      case (target_format_ff)
         FMT_RGB555: fmt = FMT_RGB555;
         FMT_RGB888: fmt = FMT_RGB888;
         default:    fmt = FMT_XRGB8888;
      endcase
   end

   // padded row length in bytes: whole 32-bit words
   assign row_bits  = PROD_W'(sb) * PROD_W'(rp) + PROD_W'(31);
   assign row_bytes = {PIX_W'(row_bits >> 5), 2'b00};

   // gather the byte and cut out one pixel code
   assign acc_merge = acc_ff | (ACC_W'(req_src_byte) << held_ff);
   assign held_sum  = held_ff + SB_W'(8);
   assign code      = acc_merge[31:0] & (32'hffff_ffff >> (SRC_BITS_MAX - sb));
   assign pix_open  = pixel_ff < rp;
   assign emit      = pix_open && (held_sum >= sb);
   assign pixel_inc = {1'b0, pixel_ff} + (PIX_W+1)'(1);
   assign byte_inc  = {1'b0, byte_ff} + (BYTE_W+1)'(1);
   assign row_done  = byte_inc >= {1'b0, row_bytes};

   // target layout
   always_comb begin
      if (fmt == FMT_RGB555) begin
         fbits   = FIELD_W_555;
         tmask_r = MASK555_R;
         tmask_g = MASK555_G;
         tmask_b = MASK555_B;
      end else begin
         fbits   = FIELD_W_888;
         tmask_r = MASK888_R;
         tmask_g = MASK888_G;
         tmask_b = MASK888_B;
      end
      case (fmt)
         FMT_RGB555: tbits = TBITS_555;
         FMT_RGB888: tbits = TBITS_888;
         default:    tbits = TBITS_8888;
      endcase
   end

   // convert the fields, or pass the code through when layouts match
   assign fld_r = pick_field(code, red_mask_ff, fbits);
   assign fld_g = pick_field(code, green_mask_ff, fbits);
   assign fld_b = pick_field(code, blue_mask_ff, fbits);

   assign passthrough = (sb == tbits) && (red_mask_ff == tmask_r) &&
                        (green_mask_ff == tmask_g) && (blue_mask_ff == tmask_b) &&
                        !alpha_present_ff;

   always_comb begin
      if (passthrough) begin
         pixel_value = code;
      end else if (fmt == FMT_RGB555) begin
         pixel_value = {17'b0, fld_r[4:0], fld_g[4:0], fld_b[4:0]};
      end else begin
         pixel_value = {8'b0, fld_r, fld_g, fld_b};
      end
   end

   // next row state
   always_comb begin
      acc_in   = acc_ff;
      held_in  = held_ff;
      pixel_in = pixel_ff;
      byte_in  = byte_inc[BYTE_W-1:0];
      if (pix_open) begin
         if (emit) begin
            acc_in   = acc_merge >> sb;
            held_in  = held_sum - sb;
            pixel_in = pixel_inc[PIX_W-1:0];
         end else begin
            acc_in  = acc_merge;
            held_in = held_sum;
         end
      end
      if (row_done) begin
         acc_in   = '0;
         held_in  = '0;
         pixel_in = '0;
         byte_in  = '0;
      end
   end

   // handshake: take a byte whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // advance row state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         held_ff  <= '0;
         pixel_ff <= '0;
         byte_ff  <= '0;
      end else if (req_fire) begin
         acc_ff   <= acc_in;
         held_ff  <= held_in;
         pixel_ff <= pixel_in;
         byte_ff  <= byte_in;
      end
   end

   // result valid: load on a completed pixel, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload: hold until replaced
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_pixel_ff <= pixel_value;
         rsp_last_ff  <= (pixel_inc == {1'b0, rp});
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_row_last  = rsp_last_ff;

endmodule

### src/mrpfc_checker.sv
// ----------------------------------------------------------------------------
// mrpfc_checker
// Port-level checks of the pixel format converter handshake and stalling.
// ----------------------------------------------------------------------------
`include "masked_rgb_pixel_format_convert_macros.svh"

module mrpfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_out,
   input logic        rsp_row_last
);

   // a stalled result keeps its payload
   `MRPFC_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_row_last)))

   // a stalled result blocks the input side
   `MRPFC_ASSERT_RST(a_stall_blocks, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready)

   // an empty or draining result register takes a byte
   `MRPFC_ASSERT_RST(a_free_ready, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready)

   // reset empties the result register
   `MRPFC_ASSERT(a_reset_clear, clock, reset |=> !rsp_valid)

   // no word appears unless a byte is taken
   `MRPFC_ASSERT_RST(a_no_stray, clock, reset, (!rsp_valid && !(req_valid && req_ready)) |=> !rsp_valid)

endmodule

bind masked_rgb_pixel_format_convert mrpfc_checker u_mrpfc_checker (.*);

### tb/sv/mrpfc_pixel_checker.sv
// ----------------------------------------------------------------------------
// mrpfc_pixel_checker
// Watches the byte, pixel and register ports of the pixel format converter.
// It unpacks every accepted byte into its own copy of the row state, queues
// the converted pixel each completed source pixel gives, and compares every
// accepted pixel word with the oldest queued one.
// ----------------------------------------------------------------------------
module mrpfc_pixel_checker
   import mrpfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_src_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [31:0]            rsp_pixel_out,
   input  logic                   rsp_row_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] pixel;
      logic        row_last;
   } converted_pixel_type;

   converted_pixel_type converted_pixels[$];

   // register copy
   logic [SB_W-1:0]          cfg_sb;
   logic [31:0]              cfg_red;
   logic [31:0]              cfg_green;
   logic [31:0]              cfg_blue;
   logic                     cfg_alpha;
   logic [1:0]               cfg_fmt;
   logic [ROW_PIX_REG_W-1:0] cfg_rp;

   // row state
   logic [ACC_W-1:0] acc;
   logic [5:0]       held;
   logic [12:0]      pix_idx;
   logic [14:0]      byte_idx;

   function automatic int unsigned lowest_set(input logic [31:0] m);
      for (int unsigned i = 0; i < 32; i++) begin
         if (m[i]) return i;
      end
      return 0;
   endfunction

   // isolate a field, then drop low bits until it fits the target field
   function automatic logic [31:0] narrow_field(input logic [31:0] code,
                                                input logic [31:0] mask,
                                                input logic [31:0] fmax);
      int unsigned pos;
      logic [31:0] span;
      logic [31:0] v;
      pos  = lowest_set(mask);
      span = mask >> pos;
      v    = (code >> pos) & span;
      while (span > fmax) begin
         span = span >> 1;
         v    = v >> 1;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // advance the row state by one byte and queue the pixel it completes
   task automatic unpack_byte(input logic [7:0] b);
      int unsigned sb;
      int unsigned rp;
      int unsigned row_len;
      int unsigned tbits;
      target_format_type fmt;
      logic [63:0] wide;
      logic [31:0] code;
      logic [31:0] px;
      logic [31:0] r_t;
      logic [31:0] g_t;
      logic [31:0] b_t;
      logic [31:0] fmax;
      converted_pixel_type item;
      sb = 32'(cfg_sb);
      if (sb < SRC_BITS_MIN) sb = 32'(SRC_BITS_MIN);
      if (sb > SRC_BITS_MAX) sb = 32'(SRC_BITS_MAX);
      rp = 32'(cfg_rp);
      if (rp < 1) rp = 1;
      if (rp > MAX_ROW_PIXELS_DEF) rp = MAX_ROW_PIXELS_DEF;
      fmt = (cfg_fmt > FMT_XRGB8888) ? FMT_XRGB8888 : target_format_type'(cfg_fmt);
      row_len = ((sb * rp + 31) / 32) * 4;

      if (pix_idx < rp) begin
         wide = {24'b0, acc} | ({56'b0, b} << held);
         acc  = wide[ACC_W-1:0];
         held = held + 6'd8;
         if (held >= sb) begin
            case (fmt)
               FMT_RGB555: begin
                  tbits = 32'(TBITS_555);
                  r_t = MASK555_R; g_t = MASK555_G; b_t = MASK555_B;
                  fmax = (32'd1 << FIELD_W_555) - 32'd1;
               end
               FMT_RGB888: begin
                  tbits = 32'(TBITS_888);
                  r_t = MASK888_R; g_t = MASK888_G; b_t = MASK888_B;
                  fmax = (32'd1 << FIELD_W_888) - 32'd1;
               end
               default: begin
                  tbits = 32'(TBITS_8888);
                  r_t = MASK888_R; g_t = MASK888_G; b_t = MASK888_B;
                  fmax = (32'd1 << FIELD_W_888) - 32'd1;
               end
            endcase
            wide = {24'b0, acc} & ((64'd1 << sb) - 64'd1);
            code = wide[31:0];
            acc  = acc >> sb;
            held = held - 6'(sb);
            // native layout without alpha: pass the raw code
            if (sb == tbits && cfg_red == r_t && cfg_green == g_t && cfg_blue == b_t &&
                !cfg_alpha) begin
               px = code;
            end else begin
               px = (narrow_field(code, cfg_red, fmax) << lowest_set(r_t)) |
                    (narrow_field(code, cfg_green, fmax) << lowest_set(g_t)) |
                    (narrow_field(code, cfg_blue, fmax) << lowest_set(b_t));
            end
            pix_idx = pix_idx + 13'd1;
            item.pixel    = px;
            item.row_last = (pix_idx == rp);
            converted_pixels.push_back(item);
         end
      end

      // padded row done: start over
      byte_idx = byte_idx + 15'd1;
      if (byte_idx >= row_len) begin
         acc      = '0;
         held     = '0;
         pix_idx  = '0;
         byte_idx = '0;
      end
   endtask

   task automatic check_pixel();
      converted_pixel_type want;
      if (converted_pixels.size() == 0) begin
         report_mismatch("pixel word with none expected", rsp_pixel_out, '0);
      end else begin
         want = converted_pixels.pop_front();
         if (rsp_pixel_out !== want.pixel)
            report_mismatch("pixel_out", rsp_pixel_out, want.pixel);
         if (rsp_row_last !== want.row_last)
            report_mismatch("row_last", {31'b0, rsp_row_last}, {31'b0, want.row_last});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_sb    = SOURCE_BITS_RST;
         cfg_red   = RED_MASK_RST;
         cfg_green = GREEN_MASK_RST;
         cfg_blue  = BLUE_MASK_RST;
         cfg_alpha = 1'b0;
         cfg_fmt   = TARGET_FMT_RST;
         cfg_rp    = ROW_PIXELS_RST;
         acc       = '0;
         held      = '0;
         pix_idx   = '0;
         byte_idx  = '0;
         converted_pixels.delete();
      end else begin
         // a word leaving now belongs to an earlier byte: compare first
         if (rsp_valid && rsp_ready) check_pixel();
         if (req_valid && req_ready) unpack_byte(req_src_byte);
         if (csr_we) begin
            case (csr_index)
               CSR_SOURCE_BITS:   cfg_sb    = csr_wdata[SB_W-1:0];
               CSR_RED_MASK:      cfg_red   = csr_wdata;
               CSR_GREEN_MASK:    cfg_green = csr_wdata;
               CSR_BLUE_MASK:     cfg_blue  = csr_wdata;
               CSR_ALPHA_PRESENT: cfg_alpha = csr_wdata[0];
               CSR_TARGET_FORMAT: cfg_fmt   = csr_wdata[1:0];
               CSR_ROW_PIXELS:    cfg_rp    = csr_wdata[ROW_PIX_REG_W-1:0];
               default: ;
            endcase
         end
      end
      pending = converted_pixels.size();
   end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the pixel format converter with scanline bytes under a sequence of
// source and target formats: a short directed pass over native layouts,
// clamped widths, zero and oversized masks, then random rows under random
// layouts with both sides stalling. The pixel checker does the comparing.
// ----------------------------------------------------------------------------
module testbench
   import mrpfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS  = 1150;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [1:0]             FMT_UNUSED       = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [7:0]               req_src_byte;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [31:0]              rsp_pixel_out;
   logic                     rsp_row_last;
   logic                     csr_we;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   int                       fail_count;
   int                       pending;
   int unsigned              cycle_count = 0;
   int unsigned              send_idle = 0;
   int unsigned              recv_idle = 0;
   logic [SB_W-1:0]          cur_sb;
   logic [ROW_PIX_REG_W-1:0] cur_rp;

   masked_rgb_pixel_format_convert dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_byte  (req_src_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_last  (rsp_row_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   mrpfc_pixel_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_src_byte  (req_src_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_last  (rsp_row_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // stall the pixel side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // offer one byte, idling first at random; return at the accepting edge
   task automatic send_byte(input logic [7:0] b);
      logic ready_seen;
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_valid    <= 1'b1;
      req_src_byte <= b;
      do begin
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   task automatic send_bytes4(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
      send_byte(b0);
      send_byte(b1);
      send_byte(b2);
      send_byte(b3);
      req_valid <= 1'b0;
   endtask

   // hold until every queued pixel is out, then let the pipeline settle
   task automatic wait_idle();
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_format(input logic [31:0] sb_w, input logic [31:0] red,
                                 input logic [31:0] green, input logic [31:0] blue,
                                 input logic [31:0] alpha_w, input logic [31:0] fmt_w,
                                 input logic [31:0] rp_w);
      write_reg(CSR_SOURCE_BITS, sb_w);
      write_reg(CSR_RED_MASK, red);
      write_reg(CSR_GREEN_MASK, green);
      write_reg(CSR_BLUE_MASK, blue);
      write_reg(CSR_ALPHA_PRESENT, alpha_w);
      write_reg(CSR_TARGET_FORMAT, fmt_w);
      write_reg(CSR_ROW_PIXELS, rp_w);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED_INDEX, $urandom());
      csr_we <= 1'b0;
      cur_sb = sb_w[SB_W-1:0];
      cur_rp = rp_w[ROW_PIX_REG_W-1:0];
   endtask

   // fill the bits above a register's width with noise half the time
   function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] keep);
      if ($urandom_range(0, 1) == 0) return v & keep;
      return (v & keep) | ($urandom() & ~keep);
   endfunction

   function automatic logic [31:0] field_mask(input int unsigned pos, input int unsigned w);
      logic [63:0] m;
      m = ((64'd1 << w) - 64'd1) << pos;
      return m[31:0];
   endfunction

   function automatic int unsigned padded_row_bytes();
      int unsigned sb;
      int unsigned rp;
      sb = 32'(cur_sb);
      rp = 32'(cur_rp);
      if (sb < SRC_BITS_MIN) sb = 32'(SRC_BITS_MIN);
      if (sb > SRC_BITS_MAX) sb = 32'(SRC_BITS_MAX);
      if (rp < 1) rp = 1;
      if (rp > MAX_ROW_PIXELS_DEF) rp = MAX_ROW_PIXELS_DEF;
      return ((sb * rp + 31) / 32) * 4;
   endfunction

   // pick a native, a plausible or a wild source layout and a row width
   task automatic random_format();
      int unsigned kind;
      int unsigned sb;
      int unsigned fmt;
      int unsigned rp;
      int unsigned bw;
      int unsigned gw;
      int unsigned rw;
      int unsigned base;
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [31:0] alpha;
      kind  = $urandom_range(0, 9);
      alpha = 32'($urandom_range(0, 3) == 0);
      if (kind < 3) begin
         fmt = $urandom_range(FMT_RGB555, FMT_XRGB8888);
         if (fmt == FMT_RGB555) begin
            sb = 32'(TBITS_555); red = MASK555_R; green = MASK555_G; blue = MASK555_B;
         end else begin
            sb = (fmt == FMT_RGB888) ? 32'(TBITS_888) : 32'(TBITS_8888);
            red = MASK888_R; green = MASK888_G; blue = MASK888_B;
         end
         if (fmt == FMT_XRGB8888 && $urandom_range(0, 1)) fmt = 32'(FMT_UNUSED);
      end else if (kind < 8) begin
         sb   = $urandom_range(9, 32);
         bw   = $urandom_range(1, 10);
         gw   = $urandom_range(1, 10);
         rw   = $urandom_range(1, 10);
         base = $urandom_range(0, 3);
         blue  = field_mask(base, bw);
         green = field_mask(base + bw, gw);
         red   = field_mask(base + bw + gw, rw);
         fmt   = $urandom_range(0, 3);
      end else begin
         sb    = $urandom_range(0, 63);
         red   = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
         green = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
         blue  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
         fmt   = $urandom_range(0, 3);
      end
      case ($urandom_range(0, 19))
         0:       rp = 0;
         1:       rp = $urandom_range(MAX_ROW_PIXELS_DEF + 1, 8191);
         2:       rp = $urandom_range(13, 300);
         default: rp = $urandom_range(1, 12);
      endcase
      program_format(with_junk(sb, 32'h3f), red, green, blue, with_junk(alpha, 32'h1),
                     with_junk(fmt, 32'h3), with_junk(rp, 32'h1fff));
   endtask

   // whole rows mostly, sometimes ending mid-row so the next format lands there
   task automatic run_rows(inout int unsigned sent);
      int unsigned row_len;
      int unsigned n;
      logic [7:0] b;
      row_len = padded_row_bytes();
      if (row_len <= 64) begin
         n = row_len * $urandom_range(1, 4);
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, row_len - 1);
      end else begin
         n = $urandom_range(16, 64);
      end
      for (int unsigned i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b);
      end
      req_valid <= 1'b0;
      sent += n;
      wait_idle();
   endtask

   initial begin
      int unsigned sent;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_src_byte <= 8'h00;
      csr_we       <= 1'b0;
      csr_index    <= CSR_SOURCE_BITS;
      csr_wdata    <= '0;
      cur_sb        = SOURCE_BITS_RST;
      cur_rp        = ROW_PIXELS_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle = 35;
      recv_idle = 76;

      // reset layout is native 555: raw code passes through
      send_bytes4(8'hff, 8'hff, 8'h00, 8'h00);
      wait_idle();
      // alpha blocks passthrough
      program_format(32'(TBITS_555), MASK555_R, MASK555_G, MASK555_B, 1,
                     32'(FMT_RGB555), 1);
      send_bytes4(8'h5a, 8'ha5, 8'hff, 8'h00);
      wait_idle();
      // native 24-bit 888
      program_format(32'(TBITS_888), MASK888_R, MASK888_G, MASK888_B, 0,
                     32'(FMT_RGB888), 1);
      send_bytes4(8'h81, 8'h7e, 8'hc3, 8'h3c);
      wait_idle();
      // native 32-bit under the unused target code
      program_format(32'(TBITS_8888), MASK888_R, MASK888_G, MASK888_B, 0,
                     32'(FMT_UNUSED), 1);
      send_bytes4(8'hff, 8'h00, 8'hff, 8'h80);
      wait_idle();
      // width below the floor, zero red, green beyond the pixel, wide blue, zero row
      program_format(5, 32'h0, 32'hffff_fe00, 32'h0000_01ff, 0, 32'(FMT_RGB555), 0);
      send_bytes4(8'hff, 8'h01, 8'hff, 8'hff);
      wait_idle();
      // width above the ceiling, top-byte red, wide green
      program_format(40, 32'hff00_0000, 32'h00ff_ff00, 32'h0000_00ff, 0,
                     32'(FMT_RGB888), 1);
      send_bytes4(8'h12, 8'h34, 8'h56, 8'h78);
      wait_idle();

      // random rows under three idling mixes
      for (int seg = 0; seg < 3; seg++) begin
         case (seg)
            0:       begin send_idle = 35; recv_idle = 76; end
            1:       begin send_idle = 76; recv_idle = 35; end
            default: begin send_idle = 0;  recv_idle = 0;  end
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / 3) begin
            random_format();
            run_rows(sent);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
